// File: rtl/core/safvi_pkg.sv
`default_nettype none
package safvi_pkg;

  localparam int unsigned AngleFracBits = 16;
  localparam int unsigned CordicStages  = 16;
  localparam int unsigned TabFrac       = 24;
  localparam int unsigned CorrShift     = TabFrac - AngleFracBits;

  localparam int unsigned ZW = 36;
  localparam int unsigned XW = 34;

  localparam logic signed [25:0] OutLimit = 26'sd23592960;
  localparam logic signed [ZW-1:0] Deg360 = 36'sd6039797760;
  localparam logic signed [ZW-1:0] Deg180 = 36'sd3019898880;
  localparam logic signed [ZW-1:0] Deg90  = 36'sd1509949440;
  localparam logic signed [XW-1:0] CordicK = 34'sd652032875;

  typedef enum logic [1:0] {
    ModeLinear = 2'd0, ModePaired = 2'd1, ModeFoot = 2'd2, ModeSpare = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatOk = 2'd0, StatRange = 2'd1, StatSat = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RegMode = 2'd0, RegStart = 2'd1, RegStep = 2'd2, RegAdjust = 2'd3
  } reg_e;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic                  foot;
    logic                  bad_view;
    logic signed [31:0]    base;
    logic signed [ZW-1:0]  theta;
    logic signed [26:0]    span;
  } item_t;

  function automatic logic signed [ZW-1:0] foot_ang(input logic [3:0] i);
    case (i)
      4'd0: foot_ang = 36'sd4585775620;
      4'd1: foot_ang = 36'sd3830799135;
      4'd2: foot_ang = 36'sd3075822649;
      4'd3: foot_ang = 36'sd5340752106;
      4'd5: foot_ang = 36'sd2320846164;
      4'd6: foot_ang = 36'sd55926320;
      4'd7: foot_ang = 36'sd810902806;
      4'd8: foot_ang = 36'sd1565870014;
      default: foot_ang = '0;
    endcase
  endfunction

  function automatic logic signed [26:0] foot_dist(input logic [3:0] i);
    case (i)
      4'd0, 4'd2, 4'd6, 4'd8: foot_dist = 27'sd26099270;
      4'd1, 4'd3, 4'd5, 4'd7: foot_dist = 27'sd18454917;
      default: foot_dist = '0;
    endcase
  endfunction

  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
    case (i)
      5'd0:  atan_tab = 36'sd754974720;
      5'd1:  atan_tab = 36'sd445687602;
      5'd2:  atan_tab = 36'sd235489089;
      5'd3:  atan_tab = 36'sd119537938;
      5'd4:  atan_tab = 36'sd60000934;
      5'd5:  atan_tab = 36'sd30029717;
      5'd6:  atan_tab = 36'sd15018523;
      5'd7:  atan_tab = 36'sd7509720;
      5'd8:  atan_tab = 36'sd3754917;
      5'd9:  atan_tab = 36'sd1877466;
      5'd10: atan_tab = 36'sd938734;
      5'd11: atan_tab = 36'sd469367;
      5'd12: atan_tab = 36'sd234684;
      5'd13: atan_tab = 36'sd117342;
      5'd14: atan_tab = 36'sd58671;
      5'd15: atan_tab = 36'sd29336;
      5'd16: atan_tab = 36'sd14668;
      5'd17: atan_tab = 36'sd7334;
      5'd18: atan_tab = 36'sd3667;
      5'd19: atan_tab = 36'sd1834;
      5'd20: atan_tab = 36'sd917;
      5'd21: atan_tab = 36'sd458;
      5'd22: atan_tab = 36'sd229;
      5'd23: atan_tab = 36'sd115;
      default: atan_tab = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/safvi_front.sv
`default_nettype none
// Front part: computes the base angle and, in footprint mode, the reduced
// twist angle. Two register stages; the offset product is registered first.
module safvi_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [7:0]               view_number_i,
  input  wire logic [5:0]               regard_number_i,
  input  wire logic [1:0]               mode_i,
  input  wire logic signed [24:0]       start_val_i,
  input  wire logic signed [20:0]       step_i,
  input  wire logic signed [20:0]       adjust_i,
  output logic                          valid_o,
  output safvi_pkg::item_t              item_o
);
  logic signed [8:0] v_s, r_s, k_s;
  logic              odd_pair;
  logic signed [8:0] q4;

  logic               v1_q, foot1_q, bad1_q;
  logic signed [31:0] prod1_q, addend1_q;
  logic signed [24:0] start1_q;
  logic [3:0]         idx1_q;
  logic signed [8:0]  vs;

  always_comb begin
    v_s = $signed({1'b0, view_number_i}) - 9'sd1;
    r_s = $signed({3'b0, regard_number_i}) - 9'sd1;
    // Truncating divide by four and two.
    q4 = (v_s < 0) ? -((-v_s) >>> 2) : (v_s >>> 2);
    vs = (v_s < 0) ? -((-v_s) >>> 1) : (v_s >>> 1);
    odd_pair = ~vs[0];
    unique case (safvi_pkg::mode_e'(mode_i))
      safvi_pkg::ModePaired: k_s = q4;
      safvi_pkg::ModeFoot:   k_s = r_s;
      default:               k_s = v_s;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q  <= 32'(k_s) * 32'(step_i);
    start1_q <= start_val_i;
    foot1_q  <= (mode_i == safvi_pkg::ModeFoot);
    bad1_q   <= (mode_i == safvi_pkg::ModeFoot) && (v_s < 0 || v_s > 9'sd8);
    idx1_q   <= v_s[3:0];
    addend1_q <= (mode_i == safvi_pkg::ModePaired) ?
                 (odd_pair ? 32'(adjust_i) : -32'(adjust_i)) : 32'sd0;
  end

  // Stage two: twist angle reduction.
  logic signed [safvi_pkg::ZW-1:0] t0, t1;
  always_comb begin
    t0 = safvi_pkg::foot_ang(idx1_q) -
         (safvi_pkg::ZW'(prod1_q) <<< safvi_pkg::CorrShift);
    // The offset can reach almost three turns; up to three wraps are applied
    // on the positive side and two on the negative side.
    t1 = t0;
    if (t1 >= safvi_pkg::Deg180) t1 = t1 - safvi_pkg::Deg360;
    if (t1 >= safvi_pkg::Deg180) t1 = t1 - safvi_pkg::Deg360;
    if (t1 >= safvi_pkg::Deg180) t1 = t1 - safvi_pkg::Deg360;
    if (t1 < -safvi_pkg::Deg180) t1 = t1 + safvi_pkg::Deg360;
    if (t1 < -safvi_pkg::Deg180) t1 = t1 + safvi_pkg::Deg360;
    if (t1 > safvi_pkg::Deg90) t1 = safvi_pkg::Deg180 - t1;
    else if (t1 < -safvi_pkg::Deg90) t1 = -safvi_pkg::Deg180 - t1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    item_o.foot     <= foot1_q;
    item_o.bad_view <= bad1_q;
    item_o.base     <= 32'(start1_q) + prod1_q + addend1_q;
    item_o.theta    <= t1;
    item_o.span     <= safvi_pkg::foot_dist(idx1_q);
  end
endmodule
`default_nettype wire

// File: rtl/core/safvi_back.sv
`default_nettype none
// Back part: pipelined CORDIC, one rotation per stage, then distance
// multiply, rounding and saturation.
module safvi_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire safvi_pkg::item_t   item_i,
  output logic                    done_o,
  output logic signed [25:0]      scan_angle_o,
  output logic [1:0]              status_o
);
  localparam int unsigned N = safvi_pkg::CordicStages;
  localparam int unsigned XW = safvi_pkg::XW;
  localparam int unsigned ZW = safvi_pkg::ZW;

  function automatic logic signed [60:0] item_dist_ext(input logic signed [26:0] d);
    item_dist_ext = 61'(d);
  endfunction

  logic                 vld_q [1:N];
  logic signed [XW-1:0] x_q [1:N];
  logic signed [XW-1:0] y_q [1:N];
  logic signed [ZW-1:0] z_q [1:N];
  safvi_pkg::item_t     it_q [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                 vin;
    logic signed [XW-1:0] xin;
    logic signed [XW-1:0] yin;
    logic signed [ZW-1:0] zin;
    safvi_pkg::item_t     iin;

    // The first stage starts from the unit vector scaled by 1/CORDIC gain.
    if (i == 0) begin : g_first
      assign vin = valid_i;
      assign xin = safvi_pkg::CordicK;
      assign yin = '0;
      assign zin = item_i.theta;
      assign iin = item_i;
    end else begin : g_next
      assign vin = vld_q[i];
      assign xin = x_q[i];
      assign yin = y_q[i];
      assign zin = z_q[i];
      assign iin = it_q[i];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      it_q[i+1] <= iin;
      if (zin >= 0) begin
        x_q[i+1] <= xin - (yin >>> i);
        y_q[i+1] <= yin + (xin >>> i);
        z_q[i+1] <= zin - safvi_pkg::atan_tab(5'(i));
      end else begin
        x_q[i+1] <= xin + (yin >>> i);
        y_q[i+1] <= yin - (xin >>> i);
        z_q[i+1] <= zin + safvi_pkg::atan_tab(5'(i));
      end
    end
  end

  // Distance times sine.
  logic                 mv_q;
  safvi_pkg::item_t     mit_q;
  logic signed [60:0]   mp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= vld_q[N];
    end
  end
  always_ff @(posedge clk_i) begin
    mit_q <= it_q[N];
    mp_q  <= 61'(item_dist_ext(it_q[N].span) * 61'(y_q[N]));
  end

  logic signed [60:0] c24;
  logic signed [36:0] corr;
  logic signed [37:0] sum;
  logic signed [25:0] ang_d;
  logic [1:0]         st_d;
  always_comb begin
    c24  = (mp_q + (61'sd1 <<< 29)) >>> 30;
    corr = 37'((c24 + (61'sd1 <<< (safvi_pkg::CorrShift - 1))) >>>
               safvi_pkg::CorrShift);
    sum  = 38'(mit_q.base) + (mit_q.foot ? 38'(corr) : 38'sd0);
    st_d = safvi_pkg::StatOk;
    if (mit_q.bad_view) begin
      ang_d = '0;
      st_d  = safvi_pkg::StatRange;
    end else if (sum > 38'(safvi_pkg::OutLimit)) begin
      ang_d = safvi_pkg::OutLimit;
      st_d  = safvi_pkg::StatSat;
    end else if (sum < -38'(safvi_pkg::OutLimit)) begin
      ang_d = -safvi_pkg::OutLimit;
      st_d  = safvi_pkg::StatSat;
    end else begin
      ang_d = sum[25:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= mv_q;
    end
  end
  always_ff @(posedge clk_i) begin
    scan_angle_o <= ang_d;
    status_o     <= st_d;
  end
endmodule
`default_nettype wire

// File: rtl/core/scan_angle_from_view_index_unit.sv
`default_nettype none
// Scan angle from view index.
// An observation transaction is taken when start_i is high and busy_o is
// low; busy_o is always low, so one transaction is accepted every cycle.
// view_number_i and regard_number_i give the one-based indexes. Each
// transaction yields one result: scan_angle_o (Q16 degrees) and status_o
// (0 ok, 1 view index outside the footprint table, 2 saturated), shown for
// one cycle with done_o high, in order of acceptance.
// Results pass through the front classification registers, one rotation
// stage per CORDIC step, a distance multiply, and the rounding and
// clamping register. All modes take the same path so results stay ordered.
// Throughput is one transaction per cycle, set by the fully pipelined
// CORDIC. The receiver cannot stall; results are never held. The user must
// write registers through cfg_we_i/cfg_idx_i/cfg_data_i only while idle;
// the block does not enforce it. Reset clears all registers to zero
// (linear mode) and empties the pipeline.
module scan_angle_from_view_index_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [7:0]         view_number_i,
  input  wire logic [5:0]         regard_number_i,
  output logic                    done_o,
  output logic signed [25:0]      scan_angle_o,
  output logic [1:0]              status_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [24:0]        cfg_data_i
);
  logic [1:0]         mode_q;
  logic signed [24:0] start_q;
  logic signed [20:0] step_q, adj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      start_q <= '0;
      step_q  <= '0;
      adj_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (safvi_pkg::reg_e'(cfg_idx_i))
        safvi_pkg::RegMode:   mode_q  <= cfg_data_i[1:0];
        safvi_pkg::RegStart:  start_q <= cfg_data_i;
        safvi_pkg::RegStep:   step_q  <= cfg_data_i[20:0];
        safvi_pkg::RegAdjust: adj_q   <= cfg_data_i[20:0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so the unit is never busy.
  assign busy_o = 1'b0;

  logic             fv;
  safvi_pkg::item_t fitem;

  safvi_front u_front (
    .clk_i, .rst_ni, .start_i, .view_number_i, .regard_number_i,
    .mode_i(mode_q), .start_val_i(start_q), .step_i(step_q),
    .adjust_i(adj_q), .valid_o(fv), .item_o(fitem)
  );

  safvi_back u_back (
    .clk_i, .rst_ni, .valid_i(fv), .item_i(fitem),
    .done_o, .scan_angle_o, .status_o
  );

  // Every accepted transaction surfaces as a done_o pulse.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(safvi_pkg::CordicStages + 4) done_o)
    else $error("result missing");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == safvi_pkg::StatRange |-> scan_angle_o == 26'sd0)
    else $error("range status with nonzero angle");
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (scan_angle_o <= safvi_pkg::OutLimit &&
                scan_angle_o >= -safvi_pkg::OutLimit))
    else $error("angle beyond limit");
endmodule
`default_nettype wire

// File: sim/tb_scan_angle_from_view_index_unit.sv
`default_nettype none
module tb_scan_angle_from_view_index_unit;
  import safvi_pkg::*;

  // The full pipeline is CordicStages + 4 deep; PipeDepth adds margin.
  localparam int unsigned PipeDepth = CordicStages + 8;
  localparam longint AngLim = 11796480;
  localparam longint StepLim = 655360;

  typedef struct {
    logic signed [25:0] angle;
    status_e            stat;
  } scan_res_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [7:0]        view_number_i;
  logic [5:0]        regard_number_i;
  logic              done_o;
  logic signed [25:0] scan_angle_o;
  logic [1:0]        status_o;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [24:0]       cfg_data_i;

  scan_angle_from_view_index_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .view_number_i   (view_number_i),
    .regard_number_i (regard_number_i),
    .done_o          (done_o),
    .scan_angle_o    (scan_angle_o),
    .status_o        (status_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Footprint twist angles and distances, plus the CORDIC arctangent steps,
  // all in Q24 degrees.
  longint twist_ang_q24[9] = '{
    64'sd4585775620, 64'sd3830799135, 64'sd3075822649,
    64'sd5340752106, 64'sd0,          64'sd2320846164,
    64'sd55926320,   64'sd810902806,  64'sd1565870014
  };
  longint foot_len_q24[9] = '{
    26099270, 18454917, 26099270,
    18454917, 0,        18454917,
    26099270, 18454917, 26099270
  };
  longint atan_step_q24[24] = '{
    754974720, 445687602, 235489089, 119537938,
    60000934,  30029717,  15018523,  7509720,
    3754917,   1877466,   938734,    469367,
    234684,    117342,    58671,     29336,
    14668,     7334,      3667,      1834,
    917,       458,       229,       115
  };

  // Shadow copy of the block's registers, updated as each write lands.
  mode_e  cur_mode;
  longint cur_start;
  longint cur_step;
  longint cur_adjust;

  scan_res_t pending_angles[$];
  int        n_errors;
  int        n_sent;
  int        n_checked;
  int        n_range;
  int        n_sat;
  bit        no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A generous ceiling; a clean run needs a small fraction of this.
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Sine of an angle in Q24 degrees, returned in Q30. The angle is reduced
  // into [-180,180) and folded into [-90,90] before the rotation.
  function automatic longint cordic_sine_q30(longint t);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = 652032875;
    y = 0;
    t = t % 64'sd6039797760;
    if (t < 0) t = t + 64'sd6039797760;
    if (t >= 64'sd3019898880) t = t - 64'sd6039797760;
    if (t > 64'sd1509949440) t = 64'sd3019898880 - t;
    else if (t < -64'sd1509949440) t = -64'sd3019898880 - t;
    z = t;
    for (int i = 0; i < int'(CordicStages) && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step_q24[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step_q24[i];
      end
    end
    return y;
  endfunction

  // Expected angle and status for one observation under the current setup.
  function automatic scan_res_t predict_scan_angle(logic [7:0] vn, logic [5:0] rn);
    longint    v;
    longint    r;
    longint    a;
    longint    p;
    longint    adj;
    longint    off;
    longint    y;
    longint    corr;
    int        sh;
    scan_res_t res;
    v = longint'(vn) - 1;
    r = longint'(rn) - 1;
    res.stat = StatOk;
    if (cur_mode == ModePaired) begin
      // Divisions truncate toward zero, which matters for view number 0.
      p = v / 2 + 1;
      adj = (p % 2 != 0) ? cur_adjust : -cur_adjust;
      a = cur_start + (v / 4) * cur_step + adj;
    end else if (cur_mode == ModeFoot) begin
      if (v < 0 || v > 8) begin
        res.angle = '0;
        res.stat = StatRange;
        return res;
      end
      sh = int'(TabFrac) - int'(AngleFracBits);
      off = r * cur_step;
      y = cordic_sine_q30(twist_ang_q24[v] - (off <<< sh));
      corr = (foot_len_q24[v] * y + (64'sd1 <<< 29)) >>> 30;
      if (sh > 0) corr = (corr + (64'sd1 <<< (sh - 1))) >>> sh;
      a = cur_start + off + corr;
    end else begin
      // Linear mode; the spare mode code falls through to it as well.
      a = cur_start + v * cur_step;
    end
    if (a > 23592960) begin
      a = 23592960;
      res.stat = StatSat;
    end else if (a < -23592960) begin
      a = -23592960;
      res.stat = StatSat;
    end
    res.angle = a[25:0];
    return res;
  endfunction

  // Each result shows for one cycle with done_o; the values seen at the edge
  // are the ones that were on the ports during that cycle.
  always @(posedge clk_i) begin
    scan_res_t want;
    if (rst_ni && done_o) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected result angle=%0d status=%0d",
                 $time, scan_angle_o, status_o);
        n_errors++;
      end else begin
        want = pending_angles.pop_front();
        n_checked++;
        if (scan_angle_o !== want.angle) begin
          $display("%0t: scan_angle expected %0d actual %0d",
                   $time, want.angle, scan_angle_o);
          n_errors++;
        end
        if (status_o !== want.stat) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.stat, status_o);
          n_errors++;
        end
      end
    end
  end

  // Offers one observation and holds it until the block takes it. start_i
  // stays high afterwards so back-to-back transactions need no gap; an idle
  // gap, when one is drawn, lowers it.
  task automatic send_obs(logic [7:0] vn, logic [5:0] rn);
    scan_res_t want;
    start_i <= 1'b1;
    view_number_i <= vn;
    regard_number_i <= rn;
    do @(posedge clk_i); while (busy_o);
    want = predict_scan_angle(vn, rn);
    pending_angles = {pending_angles, want};
    n_sent++;
    if (want.stat == StatRange) n_range++;
    if (want.stat == StatSat) n_sat++;
    if (!no_idle && $urandom_range(0, 99) < 27) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Lets every outstanding result come back so that registers change only
  // while the pipeline is empty.
  task automatic drain_pipe();
    start_i <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
  endtask

  // Writes all four registers on consecutive cycles. The data port is wider
  // than the narrower registers; the block keeps only their low bits.
  task automatic program_regs(mode_e m, longint st, longint sp, longint aj);
    reg_e   idx;
    longint val;
    drain_pipe();
    for (int i = 0; i < 4; i++) begin
      idx = reg_e'(i);
      case (idx)
        RegMode:  val = longint'(m);
        RegStart: val = st;
        RegStep:  val = sp;
        default:  val = aj;
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= val[24:0];
      @(posedge clk_i);
      case (idx)
        RegMode:  cur_mode = m;
        RegStart: cur_start = st;
        RegStep:  cur_step = sp;
        default:  cur_adjust = aj;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic longint pick_angle(longint lim);
    case ($urandom_range(0, 3))
      0: return -lim;
      1: return lim;
      default: return longint'($urandom_range(0, 2 * lim)) - lim;
    endcase
  endfunction

  task automatic test_linear();
    program_regs(ModeLinear, 1000, 65536, 0);
    send_obs(8'd1, 6'd1);
    send_obs(8'd255, 6'd63);
    send_obs(8'd0, 6'd0);
    send_obs(8'd2, 6'd5);
  endtask

  task automatic test_paired();
    program_regs(ModePaired, -5000, 131072, 4096);
    for (int i = 0; i <= 8; i++) send_obs(8'(i), 6'd1);
  endtask

  task automatic test_footprint();
    // Views 1..9 hit the table; 0, 10 and 255 are outside it.
    program_regs(ModeFoot, 0, 217088, 0);
    send_obs(8'd1, 6'd1);
    send_obs(8'd5, 6'd0);
    send_obs(8'd9, 6'd63);
    send_obs(8'd0, 6'd1);
    send_obs(8'd10, 6'd1);
    send_obs(8'd255, 6'd63);
  endtask

  task automatic test_spare_and_saturation();
    // The spare mode code behaves as linear; large steps push past the clamp
    // on the positive side.
    program_regs(ModeSpare, AngLim, StepLim, -StepLim);
    send_obs(8'd255, 6'd2);
    send_obs(8'd0, 6'd0);
    program_regs(ModeLinear, -AngLim, StepLim, StepLim);
    send_obs(8'd0, 6'd0);
    send_obs(8'd255, 6'd63);
  endtask

  // Random phases: a fresh setup per phase, extremes drawn often. In
  // footprint mode most views land inside the table so the CORDIC path sees
  // real work, and the rest probe the out-of-table flag.
  task automatic test_random();
    logic [7:0] vn;
    for (int ph = 0; ph < 12; ph++) begin
      program_regs(mode_e'($urandom_range(0, 3)), pick_angle(AngLim),
                   pick_angle(StepLim), pick_angle(StepLim));
      no_idle = (ph == 5);
      for (int k = 0; k < 75; k++) begin
        if (cur_mode == ModeFoot && $urandom_range(0, 9) < 8)
          vn = 8'($urandom_range(1, 9));
        else
          vn = 8'($urandom_range(0, 255));
        send_obs(vn, 6'($urandom_range(0, 63)));
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    int guard;
    rst_ni = 1'b0;
    start_i = 1'b0;
    view_number_i = '0;
    regard_number_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegMode;
    cfg_data_i = '0;
    cur_mode = ModeLinear;
    cur_start = 0;
    cur_step = 0;
    cur_adjust = 0;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_range = 0;
    n_sat = 0;
    no_idle = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_linear();
    test_paired();
    test_footprint();
    test_spare_and_saturation();
    test_random();

    start_i <= 1'b0;
    guard = 0;
    while (pending_angles.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (PipeDepth) @(posedge clk_i);
    if (pending_angles.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_angles.size());
      n_errors++;
    end

    $display("Sent %0d observations over all four mode codes, %0d results checked.",
             n_sent, n_checked);
    $display("Of those, %0d were outside the footprint table and %0d saturated.",
             n_range, n_sat);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
